// ----- src/brb_pkg.sv -----
// Shared types and constants for the byte ring buffer burst core.
package brb_pkg;

    // Default geometry
    localparam int BRB_DEPTH     = 1024;
    localparam int BRB_MAX_BURST = 8;

    // Field widths fixed by the stream format
    localparam int LEN_W    = 4;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 11;
    localparam int BYTE_IDX_W = 3;   // byte lane within the 64-bit word

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // Request kinds
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd3;

    // Classified request handed from front to back
    typedef struct packed {
        logic                func;
        logic [LEN_W-1:0]    len;
        logic [DATA_W-1:0]   wdata;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   used;
    } cmd_t;

endpackage

// ----- src/brb_front.sv -----
// Front end: accepts requests, checks them against the used count, emits commands.
module brb_front import brb_pkg::*; #(
    parameter int DEPTH     = BRB_DEPTH,
    parameter int MAX_BURST = BRB_MAX_BURST
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [3:0] length, [67:4] write_data, rest zero
    input  logic [0:0]  s_tuser,   // [0] func
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int UW = $clog2(DEPTH + 1);
    localparam int CW = UW + LEN_W;

    logic [UW-1:0]     used_reg, used_next;
    logic [LEN_W-1:0]  len;
    logic [CW-1:0]     len_ext, used_ext, room_ext;
    logic [CW-1:0]     after_ext;
    logic [STATUS_W-1:0] status;
    logic [UW+USED_W-1:0] used_wide;

    assign len      = s_tdata[3:0];
    assign len_ext  = CW'(len);
    assign used_ext = CW'(used_reg);
    assign room_ext = CW'(DEPTH) - used_ext;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Classify the request against the bytes committed so far
    always_comb begin
        status    = ST_OK;
        after_ext = used_ext;
        if (len == '0 || len_ext > CW'(MAX_BURST)) begin
            status = ST_BAD_LEN;
        end else if (s_tuser[0] == FUNC_READ) begin
            if (len_ext > used_ext) begin
                status = ST_NO_DATA;
            end else begin
                after_ext = used_ext - len_ext;
            end
        end else begin
            if (len_ext > room_ext) begin
                status = ST_NO_ROOM;
            end else begin
                after_ext = used_ext + len_ext;
            end
        end
        used_next = after_ext[UW-1:0];
    end

    assign used_wide = (UW + USED_W)'(used_next);

    always_comb begin
        q_cmd.func   = s_tuser[0];
        q_cmd.len    = len;
        q_cmd.wdata  = s_tdata[67:4];
        q_cmd.status = status;
        q_cmd.used   = used_wide[USED_W-1:0];
    end

    // Used count tracks every accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (q_push) begin
            used_reg <= used_next;
        end
    end

endmodule

// ----- src/brb_cmd_queue.sv -----
// Two-entry command queue between the front and back ends.
module brb_cmd_queue import brb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output cmd_t pop_cmd
);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_cmd  = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/brb_back.sv -----
// Back end: moves bytes through the single-port store and drives the result stream.
module brb_back import brb_pkg::*; #(
    parameter int DEPTH = BRB_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_nonempty,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [1:0] status, [65:2] read_data, [76:66] used_count
);

    localparam int AW = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [BYTE_IDX_W-1:0] cnt_reg;
    logic [AW-1:0]         rp_reg, wp_reg;
    logic [DATA_W-1:0]     rdata_reg, rdata_cur;
    logic                  rd_vld_reg;
    logic [BYTE_IDX_W-1:0] rd_idx_reg;
    logic [7:0]            mem [DEPTH];
    logic [7:0]            mem_q;
    logic [AW-1:0]         addr;
    logic                  mem_we, mem_re, last;
    logic [LEN_W-1:0]      len_m1;
    logic                  out_free;
    logic                  m_tvalid_reg;
    logic [79:0]           m_tdata_reg;

    assign len_m1   = cmd_reg.len - 1'b1;
    assign last     = (cnt_reg == len_m1[BYTE_IDX_W-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && q_nonempty;
    assign mem_we   = (state_reg == S_RUN) && (cmd_reg.func == FUNC_WRITE);
    assign mem_re   = (state_reg == S_RUN) && (cmd_reg.func == FUNC_READ);
    assign addr     = mem_we ? wp_reg : rp_reg;

    // Byte store, one access per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr] <= cmd_reg.wdata[{cnt_reg, 3'b000} +: 8];
        end else begin
            mem_q <= mem[addr];
        end
    end

    // Merge the byte returned by the store into the read word
    assign rdata_cur = rd_vld_reg
                     ? (rdata_reg | ({{(DATA_W-8){1'b0}}, mem_q} << {rd_idx_reg, 3'b000}))
                     : rdata_reg;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (q_nonempty) begin
                state_next = (q_cmd.status == ST_OK) ? S_RUN : S_FIN;
            end
            S_RUN:  if (last) state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= mem_re;
            if (mem_we) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (mem_re) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= cnt_reg;
        if (q_pop) begin
            cmd_reg   <= q_cmd;
            cnt_reg   <= '0;
            rdata_reg <= '0;
        end else begin
            rdata_reg <= rdata_cur;
            if (state_reg == S_RUN) cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == S_FIN && out_free) begin
            m_tdata_reg <= {3'b000, cmd_reg.used, rdata_cur, cmd_reg.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- src/byte_ring_buffer_burst_core.sv -----
// Top level of the byte ring buffer with burst read and write requests.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+---------
//  s_       | in  | length[3:0], write_data[67:4]               | func[0]
//  m_       | out | status[1:0], read_data[65:2], used[76:66]   | -
//
// A request is checked by the front end in the cycle it is taken and queued.
// The back end moves an accepted request through the single-port store one byte
// per cycle and then finishes it; a refused request goes straight to finishing.
// Reset clears the pointers, the used count, the queue and the output stage;
// the byte store itself is not cleared. Either side may stall independently.
module byte_ring_buffer_burst_core import brb_pkg::*; #(
    parameter int DEPTH     = BRB_DEPTH,
    parameter int MAX_BURST = BRB_MAX_BURST
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [3:0] length, [67:4] write_data, rest zero
    input  logic [0:0]  s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [1:0] status, [65:2] read_data, [76:66] used_count
);

    logic q_push, q_full, q_pop, q_nonempty;
    cmd_t push_cmd, pop_cmd;

    brb_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    brb_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .pop_cmd  (pop_cmd)
    );

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_nonempty (q_nonempty),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
